/* design/components_after_vertex_removal_top_defines.svh */
// ----------------------------------------------------------------------------
// components_after_vertex_removal_top_defines.svh
// assertion macros shared by the component counter rtl
// ----------------------------------------------------------------------------
`ifndef COMPONENTS_AFTER_VERTEX_REMOVAL_TOP_DEFINES_SVH
`define COMPONENTS_AFTER_VERTEX_REMOVAL_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CAVR_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("cavr assertion failed");

// next-cycle implication, disabled during reset
`define CAVR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("cavr assertion failed");

`endif

/* design/cavr_pkg.sv */
// ----------------------------------------------------------------------------
// cavr_pkg
// shared types and constants of the component counter
// ----------------------------------------------------------------------------
package cavr_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int FIELD_W      = 7;
  localparam int RESULT_MAX   = 63;

  localparam logic KIND_EDGE  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef logic [MAX_VERTICES-1:0] row_t;
  typedef logic [IDX_W-1:0]        idx_t;

  // result of the lowest-set-bit unit
  typedef struct packed {
    logic found;
    idx_t idx;
    row_t onehot;
  } lowbit_t;

endpackage

/* design/cavr_ram.sv */
// ----------------------------------------------------------------------------
// cavr_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module cavr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/cavr_lowbit.sv */
// ----------------------------------------------------------------------------
// cavr_lowbit
// lowest set bit of a vertex set: one-hot isolate and index encode
// ----------------------------------------------------------------------------
module cavr_lowbit (
  input  cavr_pkg::row_t    word,
  output cavr_pkg::lowbit_t res
);

  cavr_pkg::row_t iso;
  cavr_pkg::idx_t idx;

  // two's complement trick keeps only the lowest one
  assign iso = word & (~word + cavr_pkg::row_t'(1));

  always_comb begin
    idx = '0;
    for (int i = 0; i < cavr_pkg::MAX_VERTICES; i++) begin
      if (iso[i]) begin
        idx = idx | cavr_pkg::idx_t'(i);
      end
    end
  end

  assign res.found  = |word;
  assign res.idx    = idx;
  assign res.onehot = iso;

endmodule

/* design/components_after_vertex_removal_top.sv */
// ----------------------------------------------------------------------------
// components_after_vertex_removal_top
// adjacency bit matrix with edge insert and component count after removing
// one vertex
// ----------------------------------------------------------------------------
//  channel | dir | handshake                   | payload
//  in_     | in  | in_tvalid / in_tready       | tdata: first, second vertex; tuser: kind
//  out_    | out | out_tvalid / out_tready     | tdata: links_needed
//  cfg_    | in  | cfg_wr_en                   | cfg_wr_data: vertex_count
//
//  an edge transaction reads and rewrites both rows in E_RD_A, E_WR_A,
//  E_RD_B and E_WR_B (read-modify-write through the one ram port pair); an
//  out-of-range edge is dropped at its accept and leaves the block idle
//  a query walks through Q_SCAN and Q_MERGE, then ends in Q_DONE; each
//  reached vertex costs one row read of the matrix ram, and each step
//  goes through the shared lowbit unit
//  reset clears the matrix at once through per-row valid bits
//  in_tready is high only while idle; a query result waits in the output
//  register, and a further query stalls at its end while that result is held
// ----------------------------------------------------------------------------
`include "components_after_vertex_removal_top_defines.svh"

module components_after_vertex_removal_top (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [6:0] first_vertex, [13:7] second_vertex, [15:14] zero
  input  logic        in_tuser,    // [0] kind
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [6:0] links_needed, [7] zero
  // configuration
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data
);

  typedef enum logic [2:0] {
    IDLE,
    E_RD_A,   // read first endpoint row
    E_WR_A,   // write first endpoint row with second bit set
    E_RD_B,
    E_WR_B,
    Q_SCAN,   // pick a pending vertex or a new seed
    Q_MERGE,  // fold the fetched row into visited and pending
    Q_DONE
  } state_t;

  state_t                  state_r, state_nxt;
  logic [6:0]              vcount_r, vcount_nxt;
  cavr_pkg::row_t          row_valid_r, row_valid_nxt;
  cavr_pkg::row_t          allowed_r, allowed_nxt;
  cavr_pkg::row_t          visited_r, visited_nxt;
  cavr_pkg::row_t          pending_r, pending_nxt;
  logic [cavr_pkg::CNT_W-1:0] count_r, count_nxt;
  cavr_pkg::idx_t          va_r, va_nxt;
  cavr_pkg::idx_t          vb_r, vb_nxt;
  logic                    rd_valid_r, rd_valid_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [cavr_pkg::FIELD_W-1:0] out_data_r, out_data_nxt;

  // input fields
  logic [cavr_pkg::FIELD_W-1:0] first_vertex, second_vertex;
  logic                         kind;
  logic                         accept;
  logic                         edge_ok;

  // matrix ram
  logic            ram_we;
  cavr_pkg::idx_t  ram_waddr, ram_raddr;
  cavr_pkg::row_t  ram_wdata, ram_rdata, row_word;

  // shared lowest-bit unit
  cavr_pkg::row_t    lb_word;
  cavr_pkg::lowbit_t lb;
  logic              pend_any;

  cavr_pkg::row_t               allowed_q;
  logic [cavr_pkg::FIELD_W-1:0] result;

  assign first_vertex  = in_tdata[6:0];
  assign second_vertex = in_tdata[13:7];
  assign kind          = in_tuser;

  assign in_tready  = (state_r == IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_data_r};

  // both endpoints must lie in 1..MAX_VERTICES, the range of the matrix
  assign edge_ok = (first_vertex != '0) && (int'(first_vertex) <= cavr_pkg::MAX_VERTICES) &&
                   (second_vertex != '0) && (int'(second_vertex) <= cavr_pkg::MAX_VERTICES);

  // vertices in play for a query: below the clamped count, minus the removed one
  always_comb begin
    int n;
    n = (int'(vcount_r) > cavr_pkg::MAX_VERTICES) ? cavr_pkg::MAX_VERTICES : int'(vcount_r);
    for (int i = 0; i < cavr_pkg::MAX_VERTICES; i++) begin
      allowed_q[i] = (i < n) && (int'(first_vertex) != i + 1);
    end
  end

  // rows never written read as empty
  assign row_word = rd_valid_r ? ram_rdata : '0;

  // pending walk first, fresh seed otherwise
  assign pend_any = |pending_r;
  assign lb_word  = pend_any ? pending_r : (allowed_r & ~visited_r);

  cavr_lowbit u_lowbit (
    .word (lb_word),
    .res  (lb)
  );

  always_comb begin
    case (state_r)
      E_RD_A:  ram_raddr = va_r;
      E_RD_B:  ram_raddr = vb_r;
      Q_SCAN:  ram_raddr = lb.idx;
      default: ram_raddr = va_r;
    endcase
  end

  assign ram_we    = (state_r == E_WR_A) || (state_r == E_WR_B);
  assign ram_waddr = (state_r == E_WR_A) ? va_r : vb_r;
  assign ram_wdata = row_word | ((state_r == E_WR_A) ? (cavr_pkg::row_t'(1) << vb_r)
                                                     : (cavr_pkg::row_t'(1) << va_r));

  cavr_ram #(
    .WIDTH (cavr_pkg::MAX_VERTICES),
    .DEPTH (cavr_pkg::MAX_VERTICES)
  ) u_matrix (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // components minus one, -1 when nothing remains, saturated at RESULT_MAX
  always_comb begin
    if (count_r == '0) begin
      result = '1;
    end else if (int'(count_r) - 1 > cavr_pkg::RESULT_MAX) begin
      result = cavr_pkg::FIELD_W'(cavr_pkg::RESULT_MAX);
    end else begin
      result = cavr_pkg::FIELD_W'(count_r - cavr_pkg::CNT_W'(1));
    end
  end

  always_comb begin
    state_nxt     = state_r;
    vcount_nxt    = vcount_r;
    row_valid_nxt = row_valid_r;
    allowed_nxt   = allowed_r;
    visited_nxt   = visited_r;
    pending_nxt   = pending_r;
    count_nxt     = count_r;
    va_nxt        = va_r;
    vb_nxt        = vb_r;
    rd_valid_nxt  = row_valid_r[ram_raddr];
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (cfg_wr_en) begin
      vcount_nxt = cfg_wr_data;
    end

    // result taken by the sink
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      IDLE: begin
        if (accept) begin
          if (kind == cavr_pkg::KIND_QUERY) begin
            allowed_nxt = allowed_q;
            visited_nxt = '0;
            pending_nxt = '0;
            count_nxt   = '0;
            state_nxt   = Q_SCAN;
          end else if (edge_ok) begin
            va_nxt    = cavr_pkg::idx_t'(first_vertex - 1'b1);
            vb_nxt    = cavr_pkg::idx_t'(second_vertex - 1'b1);
            state_nxt = E_RD_A;
          end
        end
      end
      E_RD_A: state_nxt = E_WR_A;
      E_WR_A: begin
        row_valid_nxt[va_r] = 1'b1;
        state_nxt           = E_RD_B;
      end
      E_RD_B: state_nxt = E_WR_B;
      E_WR_B: begin
        row_valid_nxt[vb_r] = 1'b1;
        state_nxt           = IDLE;
      end
      Q_SCAN: begin
        if (pend_any) begin
          // row of lb.idx is fetched this cycle
          pending_nxt = pending_r & ~lb.onehot;
          state_nxt   = Q_MERGE;
        end else if (lb.found) begin
          // new component seed
          count_nxt   = count_r + cavr_pkg::CNT_W'(1);
          visited_nxt = visited_r | lb.onehot;
          pending_nxt = lb.onehot;
        end else begin
          state_nxt = Q_DONE;
        end
      end
      Q_MERGE: begin
        visited_nxt = visited_r | (row_word & allowed_r & ~visited_r);
        pending_nxt = pending_r | (row_word & allowed_r & ~visited_r);
        state_nxt   = Q_SCAN;
      end
      Q_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = result;
          state_nxt     = IDLE;
        end
      end
      default: state_nxt = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      vcount_r    <= 7'd64;
      row_valid_r <= '0;
      visited_r   <= '0;
      pending_r   <= '0;
      count_r     <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vcount_r    <= vcount_nxt;
      row_valid_r <= row_valid_nxt;
      visited_r   <= visited_nxt;
      pending_r   <= pending_nxt;
      count_r     <= count_nxt;
      rd_valid_r  <= rd_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    allowed_r  <= allowed_nxt;
    va_r       <= va_nxt;
    vb_r       <= vb_nxt;
    out_data_r <= out_data_nxt;
  end

  // every pending vertex has already been marked visited
  `CAVR_ASSERT_IMPL(a_pend_in_visited, clk, rst_n, 1'b1, (pending_r & ~visited_r) == '0)
  // the walk never enters a removed or unused vertex
  `CAVR_ASSERT_IMPL(a_visited_allowed, clk, rst_n, 1'b1, (visited_r & ~allowed_r) == '0)
  // a pending vertex always leads to a row fold
  `CAVR_ASSERT_NEXT(a_merge_after_pick, clk, rst_n, (state_r == Q_SCAN) && pend_any, state_r == Q_MERGE)
  // component count stays within the vertex range
  `CAVR_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_r <= cavr_pkg::CNT_W'(cavr_pkg::MAX_VERTICES))

endmodule

/* bench/tb_components_after_vertex_removal_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_components_after_vertex_removal_top
// edge inserts and vertex-removal queries against a bit-matrix graph model
// ----------------------------------------------------------------------------
// a queue of graph operations feeds a clocked driver; every accepted query is
// answered by a local copy of the adjacency matrix and vertex count, and a
// clocked monitor compares each result transaction with the oldest answer.
// a directed part covers empty graphs, ignored edges, self loops and the
// vertex count extremes, then random rounds grow the graph region by region
// under three idle profiles, with one long receiver stall and sender pauses
// ----------------------------------------------------------------------------
module tb_components_after_vertex_removal_top;

  // one input transaction
  typedef struct packed {
    logic       kind;
    logic [6:0] first;
    logic [6:0] second;
  } graph_op_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata    = '0;    // [6:0] first_vertex, [13:7] second_vertex, [15:14] zero
  logic        in_tuser    = 1'b0;  // [0] kind
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [7:0]  out_tdata;           // [6:0] links_needed, [7] zero
  logic        cfg_wr_en   = 1'b0;
  logic [6:0]  cfg_wr_data = '0;

  components_after_vertex_removal_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // 10 ns clock
  always #5 clk = ~clk;

  // operations waiting for the driver, and the one now on the bus
  graph_op_t  op_pending[$];
  graph_op_t  op_on_bus;
  // predicted answers, oldest first
  logic [6:0] links_expected[$];
  logic [6:0] links_want;

  // local copy of the graph
  cavr_pkg::row_t graph_rows [cavr_pkg::MAX_VERTICES];
  logic [6:0]     graph_vcount;

  // idle percentages of sender and receiver
  int send_idle_pct = 14;
  int recv_idle_pct = 87;

  // long receiver stall, requested by bumping the ticket
  int hold_ticket = 0;
  int hold_seen   = 0;
  int hold_left   = 0;

  int fault_count = 0;

  // components among the used vertices without the removed one, minus one
  function automatic logic [6:0] links_after_removal(input logic [6:0] removed);
    int             n, comps, v;
    cavr_pkg::row_t allowed, reached, frontier, fresh;
    n = (graph_vcount > cavr_pkg::MAX_VERTICES) ? cavr_pkg::MAX_VERTICES : int'(graph_vcount);
    allowed = '0;
    for (int s = 0; s < n; s++) allowed[s] = 1'b1;
    // out-of-range query vertex removes nothing
    if (removed >= 1 && int'(removed) <= n) allowed[removed - 7'd1] = 1'b0;
    reached = '0;
    comps   = 0;
    for (int s = 0; s < n; s++) begin
      if (allowed[s] && !reached[s]) begin
        comps++;
        reached[s]  = 1'b1;
        frontier    = '0;
        frontier[s] = 1'b1;
        // drain the frontier one vertex at a time, or-ing in its row
        while (frontier != '0) begin
          v = 0;
          while (!frontier[v]) v++;
          frontier[v] = 1'b0;
          fresh    = graph_rows[v] & allowed & ~reached;
          reached  = reached | fresh;
          frontier = frontier | fresh;
        end
      end
    end
    // no vertex left gives -1; large counts saturate
    if (comps == 0) return 7'h7f;
    else if (comps - 1 > cavr_pkg::RESULT_MAX) return 7'(cavr_pkg::RESULT_MAX);
    else return 7'(comps - 1);
  endfunction

  // driver: predicts on acceptance, then offers the next pending operation
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < cavr_pkg::MAX_VERTICES; i++) graph_rows[i] = '0;
      graph_vcount = 7'd64;
      in_tvalid <= 1'b0;
    end else begin
      // register write lands at this edge too
      if (cfg_wr_en) graph_vcount = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        if (op_on_bus.kind == cavr_pkg::KIND_EDGE) begin
          // endpoints of zero or beyond the matrix drop the edge
          if (op_on_bus.first >= 1 && op_on_bus.first <= cavr_pkg::MAX_VERTICES &&
              op_on_bus.second >= 1 && op_on_bus.second <= cavr_pkg::MAX_VERTICES) begin
            graph_rows[op_on_bus.first - 7'd1][op_on_bus.second - 7'd1] = 1'b1;
            graph_rows[op_on_bus.second - 7'd1][op_on_bus.first - 7'd1] = 1'b1;
          end
        end else begin
          links_expected.push_back(links_after_removal(op_on_bus.first));
        end
      end
      // bus free: offer the next operation or idle
      if (!in_tvalid || in_tready) begin
        if (op_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          op_on_bus = op_pending.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {2'b00, op_on_bus.second, op_on_bus.first};
          in_tuser  <= op_on_bus.kind;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks result transactions and drives out_tready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_seen = 0;
      hold_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (links_expected.size() == 0) begin
          if (fault_count < 10)
            $display("%0t: unexpected result links_needed=%0d", $realtime,
                     $signed(out_tdata[6:0]));
          fault_count++;
        end else begin
          links_want = links_expected.pop_front();
          if (out_tdata[6:0] !== links_want) begin
            if (fault_count < 10)
              $display("%0t: links_needed expected %0d got %0d", $realtime,
                       $signed(links_want), $signed(out_tdata[6:0]));
            fault_count++;
          end
        end
      end
      // long stall so the block fills up and blocks its input
      if (hold_ticket != hold_seen) begin
        hold_seen = hold_ticket;
        hold_left = 1500;
        out_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic push_edge(input int a, input int b);
    graph_op_t op;
    op.kind   = cavr_pkg::KIND_EDGE;
    op.first  = 7'(a);
    op.second = 7'(b);
    op_pending.push_back(op);
  endtask

  task automatic push_query(input int v, input int junk);
    graph_op_t op;
    op.kind   = cavr_pkg::KIND_QUERY;
    op.first  = 7'(v);
    op.second = 7'(junk);
    op_pending.push_back(op);
  endtask

  // wait until everything sent and answered, plus the tail of a late edge insert
  task automatic drain_all();
    @(negedge clk);
    while (op_pending.size() != 0 || in_tvalid || links_expected.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // register write while the block is idle
  task automatic write_vcount(input int v);
    drain_all();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= 7'(v);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(negedge clk);
  endtask

  // random operations, edges mostly inside the region lo..hi
  task automatic random_round(input int lo, input int hi, input int vc, input int count);
    int a, b, pick, vc_eff;
    vc_eff = (vc > cavr_pkg::MAX_VERTICES) ? cavr_pkg::MAX_VERTICES : vc;
    for (int k = 0; k < count; k++) begin
      // now and then the sender waits for every answer
      if (k % 50 == 49 && $urandom_range(1) == 1) drain_all();
      pick = $urandom_range(99);
      if (pick < 15) begin
        // path step, leaves cut vertices
        a = $urandom_range(hi - 1, lo);
        push_edge(a, a + 1);
      end else if (pick < 22) begin
        a = $urandom_range(hi, lo);
        b = $urandom_range(hi, lo);
        push_edge(a, b);
      end else if (pick < 26) begin
        push_edge($urandom_range(cavr_pkg::MAX_VERTICES, 1),
                  $urandom_range(cavr_pkg::MAX_VERTICES, 1));
      end else if (pick < 30) begin
        // noise: raw seven-bit endpoints, mostly dropped, or a self loop
        a = $urandom_range(127);
        b = $urandom_range(1) ? $urandom_range(127) : a;
        push_edge(a, b);
      end else begin
        pick = $urandom_range(9);
        if (pick < 8) a = $urandom_range(vc_eff, 1);
        else if (pick == 8) a = 0;
        else a = $urandom_range(127);
        push_query(a, $urandom_range(127));
      end
    end
  endtask

  // stimulus sequence
  initial begin
    int lo, hi, vc;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty graph at reset vertex count
    push_query(1, 0);
    push_query(0, 127);
    push_query(127, 0);
    push_query(64, 85);
    // dropped endpoints, self loop, extreme vertices, a short path
    push_edge(0, 5);
    push_edge(65, 3);
    push_edge(127, 127);
    push_edge(64, 64);
    push_edge(1, 64);
    push_edge(2, 3);
    push_edge(3, 4);
    push_query(64, 0);
    push_query(3, 0);
    push_query(2, 42);
    // single vertex: removing it leaves nothing
    write_vcount(1);
    push_query(1, 0);
    push_query(2, 0);
    // no vertices at all
    write_vcount(0);
    push_query(5, 0);
    // count beyond the matrix acts as the full matrix
    write_vcount(127);
    push_query(64, 0);
    push_query(65, 0);
    write_vcount(2);
    push_query(1, 0);
    push_query(2, 127);

    // random rounds, two per idle profile
    for (int r = 0; r < 6; r++) begin
      lo = 1 + 11 * r;
      hi = (r == 5) ? cavr_pkg::MAX_VERTICES : lo + 10;
      vc = (r == 5) ? 127 : hi;
      write_vcount(vc);
      if (r == 2) begin
        send_idle_pct = 87;
        recv_idle_pct = 14;
      end else if (r == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // receiver holds off while the sender keeps offering
        hold_ticket++;
        for (int k = 0; k < 30; k++) begin
          if (k % 3 == 0) push_edge($urandom_range(hi, lo), $urandom_range(hi, lo));
          else push_query($urandom_range(hi, 1), $urandom_range(127));
        end
        drain_all();
      end
      random_round(lo, hi, vc, 200);
    end

    drain_all();
    // tail for a result still in flight
    repeat (300) @(posedge clk);
    if (fault_count == 0 && links_expected.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // hang guard
  initial begin
    #20000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
